@@ hdl/hmac_pkg.sv @@
`timescale 1ns / 1ps

package hmac_pkg;

  localparam int KEY_WORDS = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int LEN_W = 61;

  localparam logic [7:0] IPAD_BYTE = 8'd54;
  localparam logic [7:0] OPAD_BYTE = 8'd92;
  // Outer message is 64 key bytes plus the 32-byte inner digest: 96 bytes.
  localparam logic [31:0] OUTER_LEN_BITS = 32'd768;
  localparam logic [LEN_W-1:0] BLOCK_BYTES = LEN_W'(64);

  typedef logic [KEY_WORDS-1:0][63:0] key_t;
  typedef logic [7:0][31:0] chain_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } item_t;

  localparam chain_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One 32-bit word of the key block XORed with a pad byte.
  function automatic logic [31:0] key_pad_word(key_t key, logic [3:0] idx, logic [7:0] pad);
    logic [63:0] kw;
    kw = key[idx[3:1]];
    return (idx[0] ? kw[31:0] : kw[63:32]) ^ {4{pad}};
  endfunction

endpackage

@@ hdl/hmac_ifs.sv @@
`timescale 1ns / 1ps

interface hmac_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       is_last;
  modport source (output valid, data_byte, has_byte, is_last, input ready);
  modport sink (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface hmac_digest_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_0;
  logic [63:0] digest_1;
  logic [63:0] digest_2;
  logic [63:0] digest_3;
  modport source (output valid, digest_0, digest_1, digest_2, digest_3, input ready);
  modport sink (input valid, digest_0, digest_1, digest_2, digest_3, output ready);
endinterface

interface hmac_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [hmac_pkg::CFG_INDEX_W-1:0] index;
  logic [63:0]                      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/hmac_front.sv @@
`timescale 1ns / 1ps

module hmac_front (
  input  logic                 clk,
  input  logic                 rst,
  hmac_item_if.sink            item,
  output logic                 q_valid,
  output hmac_pkg::item_t      q_item,
  input  logic                 q_pop
);

  hmac_pkg::item_t                  queue [hmac_pkg::QUEUE_DEPTH];
  logic [hmac_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [hmac_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [hmac_pkg::QUEUE_PTR_W:0]   count;
  logic                             push;
  logic                             pop;

  assign item.ready = (count != (hmac_pkg::QUEUE_PTR_W+1)'(hmac_pkg::QUEUE_DEPTH));
  assign push = item.valid && item.ready;
  assign q_valid = (count != '0);
  assign pop = q_pop && q_valid;
  assign q_item = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{data_byte: item.data_byte, has_byte: item.has_byte,
                         is_last: item.is_last};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + {{hmac_pkg::QUEUE_PTR_W{1'b0}}, push}
                     - {{hmac_pkg::QUEUE_PTR_W{1'b0}}, pop};
    end
  end

endmodule

@@ hdl/hmac_core.sv @@
`timescale 1ns / 1ps

module hmac_core (
  input  logic            clk,
  input  logic            rst,
  input  hmac_pkg::key_t  key,
  input  logic            q_valid,
  input  hmac_pkg::item_t q_item,
  output logic            q_pop,
  hmac_digest_if.source   digest
);

  localparam logic [3:0] S_POP   = 4'd0;
  localparam logic [3:0] S_BYTE  = 4'd1;
  localparam logic [3:0] S_LAST  = 4'd2;
  localparam logic [3:0] S_ZERO  = 4'd3;
  localparam logic [3:0] S_LEN   = 4'd4;
  localparam logic [3:0] S_OUTK  = 4'd5;
  localparam logic [3:0] S_OUTD  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;
  localparam logic [3:0] S_CINIT = 4'd8;
  localparam logic [3:0] S_COMP  = 4'd9;
  localparam logic [3:0] S_CFIN  = 4'd10;

  logic [3:0]                   state;
  logic [3:0]                   ret;
  logic [5:0]                   rnd;
  logic [5:0]                   fill;
  logic [hmac_pkg::LEN_W-1:0]   len;
  logic [hmac_pkg::LEN_W-1:0]   len_pad;
  logic                         msg_open;
  hmac_pkg::item_t              cur;
  hmac_pkg::chain_t             hv;
  hmac_pkg::chain_t             dig;
  logic [31:0]                  v [8];
  logic [31:0]                  w [16];
  logic                         out_valid;
  logic [255:0]                 out_data;
  logic [4:0]                   lane_sh;

  logic [31:0] s1_e, ch, s0_a, maj, t1, t2, ws0, ws1, w_new;

  always_comb begin
    s1_e  = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^ {v[4][24:0], v[4][31:25]};
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    s0_a  = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^ {v[0][21:0], v[0][31:22]};
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + s1_e + ch + hmac_pkg::ROUND_K[rnd] + w[0];
    t2    = s0_a + maj;
    ws0   = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    ws1   = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    w_new = w[0] + ws0 + w[9] + ws1;
  end

  assign len_pad = len + hmac_pkg::BLOCK_BYTES;
  assign lane_sh = {~fill[1:0], 3'b000};
  assign q_pop   = (state == S_POP) && q_valid;

  assign digest.valid    = out_valid;
  assign digest.digest_0 = out_data[255:192];
  assign digest.digest_1 = out_data[191:128];
  assign digest.digest_2 = out_data[127:64];
  assign digest.digest_3 = out_data[63:0];

  function automatic logic [31:0] pad_word(logic [31:0] x, logic [1:0] lane);
    case (lane)
      2'd0:    return 32'h8000_0000;
      2'd1:    return {x[31:24], 24'h80_0000};
      2'd2:    return {x[31:16], 16'h8000};
      default: return {x[31:8], 8'h80};
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_POP;
      ret       <= S_POP;
      rnd       <= '0;
      fill      <= '0;
      len       <= '0;
      msg_open  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (digest.ready && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_POP: begin
          if (q_valid) begin
            cur <= q_item;
            if (!msg_open) begin
              // New message: chain starts from the key XOR ipad block.
              for (int j = 0; j < 16; j++) begin
                w[j] <= hmac_pkg::key_pad_word(key, 4'(j), hmac_pkg::IPAD_BYTE);
              end
              hv       <= hmac_pkg::INIT_H;
              fill     <= '0;
              len      <= '0;
              msg_open <= 1'b1;
              ret      <= S_BYTE;
              state    <= S_CINIT;
            end else begin
              state <= S_BYTE;
            end
          end
        end
        S_BYTE: begin
          state <= S_LAST;
          if (cur.has_byte) begin
            w[fill[5:2]][lane_sh +: 8] <= cur.data_byte;
            fill <= fill + 1'b1;
            len  <= len + 1'b1;
            if (fill == 6'd63) begin
              ret   <= S_LAST;
              state <= S_CINIT;
            end
          end
        end
        S_LAST: begin
          if (!cur.is_last) begin
            state <= S_POP;
          end else begin
            for (int j = 0; j < 16; j++) begin
              if (4'(j) > fill[5:2]) begin
                w[j] <= '0;
              end else if (4'(j) == fill[5:2]) begin
                w[j] <= pad_word(w[j], fill[1:0]);
              end
            end
            if (fill[5:3] == 3'b111) begin
              ret   <= S_ZERO;
              state <= S_CINIT;
            end else begin
              state <= S_LEN;
            end
          end
        end
        S_ZERO: begin
          for (int j = 0; j < 16; j++) w[j] <= '0;
          state <= S_LEN;
        end
        S_LEN: begin
          w[14] <= len_pad[hmac_pkg::LEN_W-1:29];
          w[15] <= {len_pad[28:0], 3'b000};
          ret   <= S_OUTK;
          state <= S_CINIT;
        end
        S_OUTK: begin
          dig <= hv;
          hv  <= hmac_pkg::INIT_H;
          for (int j = 0; j < 16; j++) begin
            w[j] <= hmac_pkg::key_pad_word(key, 4'(j), hmac_pkg::OPAD_BYTE);
          end
          ret   <= S_OUTD;
          state <= S_CINIT;
        end
        S_OUTD: begin
          for (int j = 0; j < 8; j++) w[j] <= dig[j];
          w[8] <= 32'h8000_0000;
          for (int j = 9; j < 15; j++) w[j] <= '0;
          w[15] <= hmac_pkg::OUTER_LEN_BITS;
          ret   <= S_DONE;
          state <= S_CINIT;
        end
        S_DONE: begin
          if (!out_valid || digest.ready) begin
            out_valid <= 1'b1;
            out_data  <= {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
            msg_open  <= 1'b0;
            fill      <= '0;
            len       <= '0;
            state     <= S_POP;
          end
        end
        S_CINIT: begin
          for (int j = 0; j < 8; j++) v[j] <= hv[j];
          rnd   <= '0;
          state <= S_COMP;
        end
        S_COMP: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          for (int j = 0; j < 15; j++) w[j] <= w[j+1];
          w[15] <= w_new;
          rnd   <= rnd + 1'b1;
          if (rnd == 6'd63) state <= S_CFIN;
        end
        S_CFIN: begin
          for (int j = 0; j < 8; j++) hv[j] <= hv[j] + v[j];
          state <= ret;
        end
        default: state <= S_POP;
      endcase
    end
  end

endmodule

@@ hdl/hmac_sha256_top.sv @@
`timescale 1ns / 1ps

// HMAC-SHA256 over a message streamed one byte per input word. The key is the
// 64 bytes held in configuration registers 0 to 7 (first byte in the top bits
// of register 0), zero padded and never hashed down; the inner hash keeps the
// key seen when a message starts and the outer hash uses the key seen when it
// ends. A word with is_last set closes the message and yields one digest word;
// a lone is_last word with no byte gives the HMAC of the empty message. Words
// land in a four-entry queue and a single SHA-256 round engine, one round per
// cycle, works them off: every full 64-byte block adds a compression, the
// first word of a message adds one for the key block, and the closing word
// takes three to four more compressions before the digest appears. The
// digest sits in an output register so the queue keeps filling while it waits.
// Configuration writes are always accepted and take effect the next cycle.
module hmac_sha256_top (
  input  logic          clk,
  input  logic          rst,
  hmac_item_if.sink     item,
  hmac_digest_if.source digest,
  hmac_cfg_if.sink      cfg
);

  hmac_pkg::key_t  key;
  logic            q_valid;
  hmac_pkg::item_t q_item;
  logic            q_pop;

  // Key register file; writes beyond the eight key words are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg.valid &&
                 cfg.index < hmac_pkg::CFG_INDEX_W'(hmac_pkg::KEY_WORDS)) begin
      key[cfg.index[2:0]] <= cfg.data;
    end
  end

  hmac_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  hmac_core u_core (
    .clk     (clk),
    .rst     (rst),
    .key     (key),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .digest  (digest)
  );

endmodule

@@ hdl/hmac_sha256_chk.sv @@
`timescale 1ns / 1ps

module hmac_sha256_chk (
  input logic         clk,
  input logic         rst,
  input logic         d_valid,
  input logic         d_ready,
  input logic [255:0] d_data,
  input logic         c_ready
);

  a_reset_no_digest: assert property (@(posedge clk) rst |=> !d_valid)
    else $error("digest valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) c_ready)
    else $error("configuration port refused a write");

  a_digest_holds: assert property (@(posedge clk) disable iff (rst)
      d_valid && !d_ready |=> d_valid)
    else $error("digest dropped before it was taken");

  a_digest_stable: assert property (@(posedge clk) disable iff (rst)
      d_valid && !d_ready |=> $stable(d_data))
    else $error("digest changed while stalled");

endmodule

bind hmac_sha256_top hmac_sha256_chk u_chk (
  .clk     (clk),
  .rst     (rst),
  .d_valid (digest.valid),
  .d_ready (digest.ready),
  .d_data  ({digest.digest_0, digest.digest_1, digest.digest_2, digest.digest_3}),
  .c_ready (cfg.ready)
);

@@ bench/hmac_sha256_checker.sv @@
`timescale 1ns / 1ps

// Watches the byte, key and digest channels, keeps its own HMAC-SHA256
// model of the block and compares every digest word with the oldest one due.
module hmac_sha256_checker (
  input  logic        clk,
  input  logic        rst,
  hmac_item_if        item,
  hmac_digest_if      digest,
  hmac_cfg_if         cfg,
  output int          fail_count,
  output int          digests_due
);

  typedef logic [7:0] block_t [64];

  logic [63:0]      key_regs [hmac_pkg::KEY_WORDS];
  hmac_pkg::chain_t inner_chain;
  block_t           msg_block;
  int unsigned      msg_fill;
  logic [60:0]      msg_bytes;
  logic             msg_open;
  logic [255:0]     digest_queue [$];

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic hmac_pkg::chain_t sha_compress(hmac_pkg::chain_t h, block_t blk);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + hmac_pkg::ROUND_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
    return h;
  endfunction

  function automatic block_t padded_key(logic [7:0] pad);
    block_t blk;
    for (int i = 0; i < 64; i++)
      blk[i] = key_regs[i/8][63-8*(i%8) -: 8] ^ pad;
    return blk;
  endfunction

  // Folds one accepted byte word into the inner hash; closes the message
  // and queues the digest when the word ends it.
  task automatic absorb_word(logic [7:0] b, logic has_b, logic last);
    block_t blk;
    hmac_pkg::chain_t outer;
    logic [63:0] bit_len;
    if (!msg_open) begin
      inner_chain = sha_compress(hmac_pkg::INIT_H, padded_key(hmac_pkg::IPAD_BYTE));
      msg_fill = 0;
      msg_bytes = '0;
      msg_open = 1'b1;
    end
    if (has_b) begin
      msg_block[msg_fill] = b;
      msg_fill++;
      msg_bytes = msg_bytes + 61'd1;
      if (msg_fill == 64) begin
        inner_chain = sha_compress(inner_chain, msg_block);
        msg_fill = 0;
      end
    end
    if (!last) return;
    msg_block[msg_fill] = 8'h80;
    for (int i = msg_fill + 1; i < 64; i++) msg_block[i] = 8'h00;
    if (msg_fill >= 56) begin
      inner_chain = sha_compress(inner_chain, msg_block);
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    end
    bit_len = ({3'b000, msg_bytes} + 64'd64) << 3;
    for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
    inner_chain = sha_compress(inner_chain, msg_block);
    outer = sha_compress(hmac_pkg::INIT_H, padded_key(hmac_pkg::OPAD_BYTE));
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < 32; i++) blk[i] = inner_chain[i/4][31-8*(i%4) -: 8];
    blk[32] = 8'h80;
    bit_len = 64'(hmac_pkg::OUTER_LEN_BITS);
    for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
    outer = sha_compress(outer, blk);
    digest_queue.push_back({outer[0], outer[1], outer[2], outer[3],
                            outer[4], outer[5], outer[6], outer[7]});
    msg_open = 1'b0;
  endtask

  always @(posedge clk) begin
    logic [255:0] want;
    if (rst) begin
      for (int i = 0; i < hmac_pkg::KEY_WORDS; i++) key_regs[i] = '0;
      msg_open = 1'b0;
      msg_fill = 0;
      msg_bytes = '0;
      digest_queue.delete();
      fail_count = 0;
    end else begin
      // Digest first: it came from words already accepted.
      if (digest.valid && digest.ready) begin
        if (digest_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected digest %h %h %h %h", $time, digest.digest_0,
                   digest.digest_1, digest.digest_2, digest.digest_3);
        end else begin
          want = digest_queue.pop_front();
          if (digest.digest_0 !== want[255:192] || digest.digest_1 !== want[191:128] ||
              digest.digest_2 !== want[127:64] || digest.digest_3 !== want[63:0]) begin
            fail_count++;
            $display("%0t: digest mismatch expected %h got %h %h %h %h", $time, want,
                     digest.digest_0, digest.digest_1, digest.digest_2, digest.digest_3);
          end
        end
      end
      // A byte word in the same cycle as a key write is folded in first, so the
      // model gives that word the old key.
      if (item.valid && item.ready)
        absorb_word(item.data_byte, item.has_byte, item.is_last);
      if (cfg.valid && cfg.ready && cfg.index < hmac_pkg::KEY_WORDS)
        key_regs[cfg.index[2:0]] = cfg.data;
    end
    digests_due = digest_queue.size();
  end
endmodule

@@ bench/hmac_sha256_top_test.sv @@
`timescale 1ns / 1ps

// Streams byte words through the HMAC block under varying key settings and
// idle patterns; the checker beside the block predicts every digest.
module hmac_sha256_top_test;

  logic clk;
  logic rst;
  int   fail_count;
  int   digests_due;
  int   send_idle_pct;
  int   take_idle_pct;
  longint cycle_count = 0;

  hmac_item_if   item ();
  hmac_digest_if digest ();
  hmac_cfg_if    cfg ();

  hmac_sha256_top u_dut (.clk(clk), .rst(rst), .item(item), .digest(digest), .cfg(cfg));

  hmac_sha256_checker u_check (.clk(clk), .rst(rst), .item(item), .digest(digest),
                               .cfg(cfg), .fail_count(fail_count),
                               .digests_due(digests_due));

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random; the rate follows the current phase.
  always @(posedge clk) begin
    if (rst) begin
      digest.ready <= 1'b0;
    end else begin
      digest.ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // Generous bound: each word can cost a full block compression plus the
  // closing passes, and stalls can triple that.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("hmac_sha256_top verification failed");
      $finish;
    end
  end

  // Sends one byte word, keeping valid low for random idle cycles before it.
  // Valid stays high afterwards until the next idle cycle or a drain.
  task automatic send_word(logic [7:0] b, logic has_b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid     <= 1'b1;
    item.data_byte <= b;
    item.has_byte  <= has_b;
    item.is_last   <= last;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
  endtask

  // A whole message of the given length; the last byte carries is_last,
  // or a byteless closing word when close_bare is set or the length is zero.
  task automatic send_message(int len, bit close_bare);
    for (int i = 0; i < len; i++)
      send_word(8'($urandom), 1'b1, (i == len - 1) && !close_bare);
    if (close_bare || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic write_key(int idx, logic [63:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= hmac_pkg::CFG_INDEX_W'(idx);
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every due digest, then lets any closing work run out.
  task automatic drain;
    item.valid <= 1'b0;
    @(posedge clk);
    while (digests_due != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_key(int kind);
    for (int i = 0; i < hmac_pkg::KEY_WORDS; i++) begin
      case (kind)
        0: write_key(i, '0);
        1: write_key(i, '1);
        default: write_key(i, (i >= 4 && kind == 3) ? 64'd0 : {$urandom, $urandom});
      endcase
    end
  endtask

  initial begin
    int len;
    rst = 1'b1;
    send_idle_pct = 24;
    take_idle_pct = 48;
    item.valid = 1'b0;
    item.data_byte = '0;
    item.has_byte = 1'b0;
    item.is_last = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset key (all zero): empty message, a lone
    // byteless non-final word, extreme bytes, and a one-byte message.
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'ha5, 1'b1, 1'b1);
    drain();
    random_key(1);
    send_message(1, 1'b1);
    send_message(0, 1'b0);
    drain();
    random_key(2);
    // A key written mid-message: the inner hash keeps the old key, the
    // outer hash sees the new one. The first word is fully worked off
    // before the write.
    send_word(8'h12, 1'b1, 1'b0);
    item.valid <= 1'b0;
    repeat (100) @(posedge clk);
    write_key(3, {$urandom, $urandom});
    send_word(8'h34, 1'b1, 1'b1);
    drain();

    // Random part in three idle phases, with a fresh key between messages.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 48 : 0;
      take_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 24 : 0;
      for (int m = 0; m < 10; m++) begin
        random_key($urandom_range(3));
        // Mostly short messages, some around block and padding edges.
        case ($urandom_range(3))
          0: len = $urandom_range(8);
          1: len = $urandom_range(54, 66);
          2: len = $urandom_range(110, 130);
          default: len = $urandom_range(20);
        endcase
        send_message(len, $urandom_range(1));
        if ($urandom_range(3) == 0) send_message(0, 1'b0);
        drain();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("hmac_sha256_top verification clean");
    end else begin
      $display("hmac_sha256_top verification failed");
    end
    $finish;
  end
endmodule
